// ===== rtl/brfb_pkg.sv =====
// brfb_pkg: shared types and constants for the byte ring FIFO with burst reads.
// Stand-alone; imported by byte_ring_fifo_burst and the testbench.

package brfb_pkg;

    // Default sizing
    localparam int DEF_MAX_DEPTH = 1024;
    localparam int DEF_MAX_BURST = 64;

    // Fixed field widths
    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int BURST_LEN_W = 7;
    localparam int COUNT_W     = 11;
    localparam int CAP_LOG2_W  = 4;

    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RESET = 4'd10;
    localparam logic [COUNT_W-1:0]    COUNT_SAT      = 11'd1024;

    // Action codes on s_axis_tuser
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 2'd2;

    // Result kinds on m_axis_tuser
    localparam logic RES_WRITE = 1'b0;
    localparam logic RES_DATA  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  data;
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_res;

endpackage

// ===== rtl/byte_ring_fifo_burst.sv =====
// byte_ring_fifo_burst: byte FIFO on a power-of-two ring in a synchronous RAM.
// A read/peek word of n bytes blocks further input until all n are issued; bytes stream
// out at one per cycle while the output queue has room, set by the single RAM read
// port. Each result is registered in stage 1, then in the output queue, before output.
// Reset (synchronous, active low) clears indices, burst count and output queue;
// capacity_log2 returns to 10. RAM contents are not cleared.
// Depends on brfb_pkg and brfb_ram.

module byte_ring_fifo_burst
    import brfb_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int MAX_BURST = DEF_MAX_BURST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration: capacity_log2
    input  logic                  i_cfg_we,
    input  logic [CAP_LOG2_W-1:0] i_cfg_wdata,

    // Input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [7:0] data_in, [14:8] burst_length, [15] 0
    input  logic [ACTION_W-1:0]   s_axis_tuser,  // [1:0] action
    input  logic                  s_axis_tlast,  // last_in

    // Result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // [7:0] data_out, [8] data_valid,
                                                 // [19:9] transfer_count, [23:20] 0
    output logic                  m_axis_tuser,  // [0] result_kind
    output logic                  m_axis_tlast   // last_out
);

    localparam int LOG_DEPTH = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ADDR_W    = LOG_DEPTH;
    localparam int IDX_W     = LOG_DEPTH + 1;            // index runs modulo 2*depth
    localparam int BURST_W   = $clog2(MAX_BURST + 1);
    localparam int CMP_W     = (IDX_W > BURST_LEN_W) ? IDX_W : BURST_LEN_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state,     n_state;
    logic [CAP_LOG2_W-1:0] r_cap_log2;
    logic [IDX_W-1:0]      r_wr_idx,    n_wr_idx;
    logic [IDX_W-1:0]      r_rd_idx,    n_rd_idx;
    logic [COUNT_W-1:0]    r_burst_acc, n_burst_acc;

    // Burst sequencer
    logic [IDX_W-1:0]      r_ptr,       n_ptr;
    logic [BURST_W-1:0]    r_left,      n_left;
    logic [BURST_W-1:0]    r_n,         n_n;

    // Stage 1: result issued, RAM read in flight when r_s1_ram
    logic                  r_s1_v,      n_s1_v;
    logic                  r_s1_ram,    n_s1_ram;
    t_res                  r_s1,        n_s1;

    // Two-slot output queue: head drives the port, skid catches the one behind
    logic                  r_head_v;
    t_res                  r_head;
    logic                  r_skid_v;
    t_res                  r_skid;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [ACTION_W-1:0]    in_action;
    logic [BYTE_W-1:0]      in_data;
    logic                   in_last;
    logic [BURST_LEN_W-1:0] in_burst_len;

    assign in_action    = s_axis_tuser;
    assign in_data      = s_axis_tdata[7:0];
    assign in_burst_len = s_axis_tdata[14:8];
    assign in_last      = s_axis_tlast;

    // ------------------------------------------------------------------
    // Capacity, fill level, slot mask
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  cap;
    logic [ADDR_W-1:0] slot_mask;
    logic [IDX_W-1:0]  fill;
    logic              can_store;

    always_comb begin
        if (r_cap_log2 == '0) begin
            cap = IDX_W'(2);
        end else if (int'(r_cap_log2) > LOG_DEPTH) begin
            cap = IDX_W'(MAX_DEPTH);
        end else begin
            cap = IDX_W'(1) << r_cap_log2;
        end
    end

    assign slot_mask = ADDR_W'(cap - IDX_W'(1));
    assign fill      = r_wr_idx - r_rd_idx;
    assign can_store = (fill < cap);

    // Bytes a read/peek will return: min(burst_length, MAX_BURST, fill)
    logic [BURST_LEN_W-1:0] want;
    logic [CMP_W-1:0]       take;
    logic [BURST_W-1:0]     take_n;

    always_comb begin
        if (int'(in_burst_len) > MAX_BURST) begin
            want = BURST_LEN_W'(MAX_BURST);
        end else begin
            want = in_burst_len;
        end
        if (CMP_W'(fill) < CMP_W'(want)) begin
            take = CMP_W'(fill);
        end else begin
            take = CMP_W'(want);
        end
        take_n = BURST_W'(take);
    end

    // ------------------------------------------------------------------
    // Credit: a new result may enter stage 1 only if the queue will have
    // room for it when it lands, whatever the sink does meanwhile.
    // ------------------------------------------------------------------
    logic       pop;
    logic [1:0] occ;
    logic       credit_ok;

    assign pop       = r_head_v & m_axis_tready;
    assign occ       = 2'(r_head_v) + 2'(r_skid_v) + 2'(r_s1_v);
    assign credit_ok = (occ <= (2'd1 + 2'(pop)));

    assign s_axis_tready = (r_state == ST_IDLE) && credit_ok;

    logic accept;
    assign accept = s_axis_tvalid & s_axis_tready;

    // ------------------------------------------------------------------
    // RAM
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    brfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_waddr = r_wr_idx[ADDR_W-1:0] & slot_mask;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] acc_inc;

    always_comb begin
        if (can_store && (r_burst_acc < COUNT_SAT)) begin
            acc_inc = r_burst_acc + COUNT_W'(1);
        end else begin
            acc_inc = r_burst_acc;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_burst_acc = r_burst_acc;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_n         = r_n;
        n_s1_v      = 1'b0;
        n_s1_ram    = 1'b0;
        n_s1        = r_s1;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx[ADDR_W-1:0] & slot_mask;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_action)
                        ACT_WRITE: begin
                            if (can_store) begin
                                ram_we   = 1'b1;
                                n_wr_idx = r_wr_idx + IDX_W'(1);
                            end
                            if (in_last) begin
                                n_s1_v      = 1'b1;
                                n_s1.kind   = RES_WRITE;
                                n_s1.data   = '0;
                                n_s1.valid  = 1'b0;
                                n_s1.count  = acc_inc;
                                n_s1.last   = 1'b1;
                                n_burst_acc = '0;
                            end else begin
                                n_burst_acc = acc_inc;
                            end
                        end
                        ACT_READ, ACT_PEEK: begin
                            n_s1_v     = 1'b1;
                            n_s1.kind  = RES_DATA;
                            n_s1.data  = '0;
                            n_s1.last  = 1'b1;
                            if (take_n == '0) begin
                                // nothing to give: one empty result
                                n_s1.valid = 1'b0;
                                n_s1.count = '0;
                            end else begin
                                ram_re     = 1'b1;
                                n_s1_ram   = 1'b1;
                                n_s1.valid = 1'b1;
                                n_s1.count = COUNT_W'(take_n);
                                n_s1.last  = (take_n == BURST_W'(1));
                                n_ptr      = r_rd_idx + IDX_W'(1);
                                n_left     = take_n - BURST_W'(1);
                                n_n        = take_n;
                                if (take_n != BURST_W'(1)) begin
                                    n_state = ST_BURST;
                                end
                                if (in_action == ACT_READ) begin
                                    n_rd_idx = r_rd_idx + IDX_W'(take_n);
                                end
                            end
                        end
                        default: begin
                            // unused action: taken and dropped
                        end
                    endcase
                end
            end
            ST_BURST: begin
                ram_raddr = r_ptr[ADDR_W-1:0] & slot_mask;
                if (credit_ok) begin
                    ram_re     = 1'b1;
                    n_s1_v     = 1'b1;
                    n_s1_ram   = 1'b1;
                    n_s1.kind  = RES_DATA;
                    n_s1.data  = '0;
                    n_s1.valid = 1'b1;
                    n_s1.count = COUNT_W'(r_n);
                    n_s1.last  = (r_left == BURST_W'(1));
                    n_ptr      = r_ptr + IDX_W'(1);
                    n_left     = r_left - BURST_W'(1);
                    if (r_left == BURST_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // capacity write clears both indices
        if (i_cfg_we) begin
            n_wr_idx = '0;
            n_rd_idx = '0;
        end
    end

    // Result landing in the queue this cycle, RAM byte merged in
    t_res push_res;
    always_comb begin
        push_res = r_s1;
        if (r_s1_ram) begin
            push_res.data = ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap_log2  <= CAP_LOG2_RESET;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_burst_acc <= '0;
            r_left      <= '0;
            r_s1_v      <= 1'b0;
            r_s1_ram    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_burst_acc <= n_burst_acc;
            r_left      <= n_left;
            r_s1_v      <= n_s1_v;
            r_s1_ram    <= n_s1_ram;
            if (i_cfg_we) begin
                r_cap_log2 <= i_cfg_wdata;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_n   <= n_n;
        r_s1  <= n_s1;
    end

    // Output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_head_v || pop) begin
            if (r_skid_v) begin
                r_head_v <= 1'b1;
                r_skid_v <= r_s1_v;
            end else begin
                r_head_v <= r_s1_v;
            end
        end else if (r_s1_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_head_v || pop) begin
            if (r_skid_v) begin
                r_head <= r_skid;
                r_skid <= push_res;
            end else begin
                r_head <= push_res;
            end
        end else if (r_s1_v) begin
            r_skid <= push_res;
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_head_v;
    assign m_axis_tdata  = {4'b0, r_head.count, r_head.valid, r_head.data};
    assign m_axis_tuser  = r_head.kind;
    assign m_axis_tlast  = r_head.last;

endmodule

// ===== rtl/brfb_ram.sv =====
// brfb_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module brfb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for byte_ring_fifo_burst, stream words in and out.
// Keeps its own copy of the ring and both indices and checks every result word in order.
// Depends on brfb_pkg and the RTL of byte_ring_fifo_burst.

module testbench;
    import brfb_pkg::*;

    // Action code that the block ignores
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_LIMIT  = 40000; // cycles allowed for outstanding results
    localparam int TAIL_CYCLES  = 12;    // block latency plus margin

    typedef struct {
        logic [ACTION_W-1:0]    action;
        logic [BYTE_W-1:0]      data;
        logic                   last_in;
        logic [BURST_LEN_W-1:0] len;
    } t_in_word;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CAP_LOG2_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;  // [7:0] data_in, [14:8] burst_length, [15] 0
    logic [ACTION_W-1:0]   s_axis_tuser  = '0;  // [1:0] action
    logic                  s_axis_tlast  = 1'b0; // last_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;        // [7:0] data_out, [8] data_valid,
                                                // [19:9] transfer_count, [23:20] 0
    logic                  m_axis_tuser;        // [0] result_kind
    logic                  m_axis_tlast;        // last_out

    // Bench-side copy of the ring
    logic [BYTE_W-1:0]     ring_copy [0:DEF_MAX_DEPTH-1];
    logic [COUNT_W-1:0]    wr_idx;
    logic [COUNT_W-1:0]    rd_idx;
    logic [COUNT_W-1:0]    open_count;   // bytes stored in the open write burst
    logic [CAP_LOG2_W-1:0] cap_log2;

    t_res pending_results [$];

    int  fail_count   = 0;
    bit  tx_quiet     = 1'b0;  // sender never idles
    bit  rx_quiet     = 1'b0;  // receiver never stalls
    bit  hold_request = 1'b0;
    logic hold_off    = 1'b0;

    byte_ring_fifo_burst dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Capacity in bytes; 0 acts as 1, anything above the ring acts as its depth
    function automatic int unsigned ring_capacity();
        int unsigned lg;
        int unsigned c;
        lg = cap_log2;
        if (lg < 1)
            lg = 1;
        c = 1 << lg;
        if (c > DEF_MAX_DEPTH)
            c = DEF_MAX_DEPTH;
        return c;
    endfunction

    function automatic void clear_ring_state();
        wr_idx     = '0;
        rd_idx     = '0;
        open_count = '0;
        cap_log2   = CAP_LOG2_RESET;
    endfunction

    task automatic predict_word(input t_in_word w);
        logic [COUNT_W-1:0] fill;
        logic [COUNT_W-1:0] idx;
        int unsigned        cap;
        int unsigned        want;
        int unsigned        n;
        t_res               r;
        cap  = ring_capacity();
        fill = wr_idx - rd_idx;
        case (w.action)
            ACT_WRITE: begin
                if (fill < cap) begin
                    ring_copy[wr_idx & (cap - 1)] = w.data;
                    wr_idx = wr_idx + 1'b1;
                    if (open_count < COUNT_SAT)
                        open_count = open_count + 1'b1;
                end
                if (w.last_in) begin
                    r.kind  = RES_WRITE;
                    r.data  = '0;
                    r.valid = 1'b0;
                    r.count = open_count;
                    r.last  = 1'b1;
                    pending_results.push_back(r);
                    open_count = '0;
                end
            end
            ACT_READ, ACT_PEEK: begin
                want = (w.len > DEF_MAX_BURST) ? DEF_MAX_BURST : w.len;
                n    = (want < fill) ? want : fill;
                if (n == 0) begin
                    // nothing to give: one empty word closes the request
                    r.kind  = RES_DATA;
                    r.data  = '0;
                    r.valid = 1'b0;
                    r.count = '0;
                    r.last  = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        idx     = rd_idx + k[COUNT_W-1:0];
                        r.kind  = RES_DATA;
                        r.data  = ring_copy[idx & (cap - 1)];
                        r.valid = 1'b1;
                        r.count = n[COUNT_W-1:0];
                        r.last  = (k == n - 1);
                        pending_results.push_back(r);
                    end
                    if (w.action == ACT_READ)
                        rd_idx = rd_idx + n[COUNT_W-1:0];
                end
            end
            default: ;  // unused code: ignored
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, w.len, w.data};
        s_axis_tuser  <= w.action;
        s_axis_tlast  <= w.last_in;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predict_word(w);
    endtask

    // Write word; the unused length field carries noise
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last_in);
        t_in_word w;
        w.action  = ACT_WRITE;
        w.data    = b;
        w.last_in = last_in;
        w.len     = $urandom_range(0, 127);
        send_word(w);
    endtask

    // Read, peek or unused word; data and last carry noise
    task automatic send_request(input logic [ACTION_W-1:0] act, input int unsigned len);
        t_in_word w;
        w.action  = act;
        w.data    = $urandom_range(0, 255);
        w.last_in = $urandom_range(0, 1);
        w.len     = len[BURST_LEN_W-1:0];
        send_word(w);
    endtask

    task automatic send_burst(input int unsigned n);
        for (int k = 0; k < n; k++)
            send_byte($urandom_range(0, 255), k == n - 1);
    endtask

    // Stop offering, wait for every pending result and the block's tail latency
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_results.size()));
            pending_results.delete();
        end
    endtask

    // Only called once the block is idle
    task automatic set_capacity(input logic [CAP_LOG2_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cap_log2 = v;
        wr_idx   = '0;
        rd_idx   = '0;
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall per word, plus the long hold-off
    // ------------------------------------------------------------------

    task automatic check_result(input logic [23:0] d, input logic k, input logic l);
        t_res e;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result word tdata=%h tuser=%b tlast=%b",
                                      d, k, l));
        end else begin
            e = pending_results.pop_front();
            if (k !== e.kind)
                report_mismatch($sformatf("result_kind %b, want %b", k, e.kind));
            if (d[7:0] !== e.data)
                report_mismatch($sformatf("data_out %h, want %h", d[7:0], e.data));
            if (d[8] !== e.valid)
                report_mismatch($sformatf("data_valid %b, want %b", d[8], e.valid));
            if (d[19:9] !== e.count)
                report_mismatch($sformatf("transfer_count %0d, want %0d", d[19:9], e.count));
            if (l !== e.last)
                report_mismatch($sformatf("last_out %b, want %b", l, e.last));
            if (d[23:20] !== 4'd0)
                report_mismatch($sformatf("tdata pad bits %h, want 0", d[23:20]));
        end
    endtask

    initial begin : receiver
        int unsigned rx_wait;
        rx_wait = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
            end
            if (hold_off || rx_wait != 0) begin
                m_axis_tready <= 1'b0;
                if (rx_wait != 0)
                    rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long hold-off, counted here so the sender keeps running meanwhile
    initial begin : hold_counter
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset capacity, empty and zero-length requests, byte extremes, long request,
    // peek against read, unused action
    task automatic test_basic_ops();
        send_request(ACT_READ, 5);      // empty buffer
        send_request(ACT_PEEK, 0);      // zero length, empty
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);         // report of 3
        send_request(ACT_PEEK, 127);    // clipped to the burst limit
        send_request(ACT_READ, 0);      // zero length with data waiting
        send_request(ACT_NONE, 64);     // ignored
        send_request(ACT_READ, 2);
        send_request(ACT_READ, 64);
        send_request(ACT_READ, 64);     // empty again
        send_byte(8'h5A, 1'b1);
        send_request(ACT_PEEK, 1);
        send_request(ACT_READ, 1);
        send_request(ACT_PEEK, 65);
        settle();
    endtask

    // Smallest ring: overflow drops, index wrap, out-of-range settings
    task automatic test_capacity_limits();
        set_capacity(4'd1);
        send_burst(4);                  // two stored, two dropped
        send_request(ACT_READ, 64);
        for (int k = 0; k < 3; k++) begin
            send_burst(2);
            send_request(ACT_READ, 1);
            send_request(ACT_PEEK, 2);
            send_request(ACT_READ, 1);
        end
        settle();
        set_capacity(4'd0);             // acts as 1
        send_burst(3);
        send_request(ACT_READ, 3);
        settle();
        set_capacity(4'd15);            // acts as full depth
        send_burst(3);
        send_request(ACT_READ, 3);
        settle();
    endtask

    // Ring of 16 fills up: the extra bytes are dropped and the report counts
    // only the stored ones, then the ring drains in one read
    task automatic test_full_ring();
        set_capacity(4'd4);
        send_burst(20);
        send_request(ACT_PEEK, 64);
        send_request(ACT_READ, 64);
        send_request(ACT_READ, 64);     // empty again
        settle();
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        set_capacity(4'd10);
        tx_quiet     = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 6; k++)
            send_burst(4);
        send_request(ACT_PEEK, 64);
        send_request(ACT_READ, 64);
        send_request(ACT_READ, 64);
        send_request(ACT_PEEK, 10);
        tx_quiet = 1'b0;
        settle();
    endtask

    // Mostly well-formed write bursts and requests, some noise and open bursts
    task automatic random_items(input int unsigned target);
        int unsigned sent;
        int unsigned pick;
        int unsigned n;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 8);
                send_burst(n);
                sent += n;
            end else if (pick < 85) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127)
                                                : $urandom_range(0, 64);
                send_request($urandom_range(0, 1) ? ACT_READ : ACT_PEEK, n);
                sent++;
            end else if (pick < 93) begin
                // stray write, may leave a burst open across requests
                send_byte($urandom_range(0, 255), $urandom_range(0, 1));
                sent++;
            end else begin
                send_request(ACT_NONE, $urandom_range(0, 127));
            end
        end
    endtask

    task automatic test_random();
        logic [CAP_LOG2_W-1:0] caps [7];
        caps = '{4'd3, 4'd1, 4'd5, 4'd10, 4'd0, 4'd12, 4'd2};
        for (int p = 0; p < 8; p++) begin
            set_capacity((p < 7) ? caps[p] : CAP_LOG2_W'($urandom_range(0, 15)));
            tx_quiet = (p == 2);
            rx_quiet = (p == 4) || (p == 6);
            random_items(6);
            settle();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : main
        for (int k = 0; k < DEF_MAX_DEPTH; k++)
            ring_copy[k] = '0;
        clear_ring_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_capacity_limits();
        test_full_ring();
        test_backpressure();
        test_random();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #16_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/brfb_pkg.sv
rtl/brfb_ram.sv
rtl/byte_ring_fifo_burst.sv
bench/testbench.sv
